// ===== hdl/clni_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clni_pkg
// Shared types and constants for the 4-bit character LCD interface.
// ----------------------------------------------------------------------------
package clni_pkg;

   // Request operation codes
   localparam logic [1:0] OP_COMMAND = 2'd0;
   localparam logic [1:0] OP_DATA    = 2'd1;
   localparam logic [1:0] OP_INIT    = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_FUNCTION_SET    = 2'd0;
   localparam logic [1:0] CSR_DISPLAY_CONTROL = 2'd1;
   localparam logic [1:0] CSR_ENTRY_MODE      = 2'd2;

   // Register reset values
   localparam logic [7:0] FUNCTION_SET_RST    = 8'h28;
   localparam logic [7:0] DISPLAY_CONTROL_RST = 8'h0C;
   localparam logic [7:0] ENTRY_MODE_RST      = 8'h06;

   // Field widths
   localparam int unsigned HOLD_W = 17;
   localparam int unsigned NIB_W  = 4;

   // Phase codes within one nibble
   localparam logic [1:0] PH_SETUP  = 2'd0;
   localparam logic [1:0] PH_STROBE = 2'd1;
   localparam logic [1:0] PH_SETTLE = 2'd2;

   // Nibble indexes that close a sequence
   localparam logic [NIB_W-1:0] NIB_LAST_BYTE = 4'd1;
   localparam logic [NIB_W-1:0] NIB_LAST_INIT = 4'd11;
   localparam logic [NIB_W-1:0] NIB_WAKE_END  = 4'd3;

   // Timing in microseconds
   localparam logic [HOLD_W-1:0] SETUP_US     = 17'd10;
   localparam logic [HOLD_W-1:0] STROBE_US    = 17'd1;
   localparam logic [HOLD_W-1:0] SETTLE_US    = 17'd50;
   localparam logic [HOLD_W-1:0] CMD_EXTRA_US = 17'd2000;
   localparam logic [HOLD_W-1:0] DAT_EXTRA_US = 17'd50;
   localparam logic [HOLD_W-1:0] CLR_EXTRA_US = 17'd4000;
   localparam logic [HOLD_W-1:0] WAKE_LONG_US = 17'd5000;
   localparam logic [HOLD_W-1:0] WAKE_SHRT_US = 17'd150;
   localparam logic [HOLD_W-1:0] POWERUP_US   = 17'd100000;

   // Wake-up nibbles and clear command
   localparam logic [3:0] WAKE_NIB_A = 4'h3;
   localparam logic [3:0] WAKE_NIB_B = 4'h2;
   localparam logic [7:0] CLEAR_CMD  = 8'h01;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POWERUP,
      ST_NIBBLE
   } ctl_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic             start;
      logic             emit;
      logic             powerup;
      logic             init;
      logic             last;
      logic [NIB_W-1:0] nib;
      logic [1:0]       ph;
   } ctl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic slot_free;
   } dp_status_type;

endpackage

// ===== hdl/char_lcd_nibble_interface_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface_top
// 4-bit character LCD driver: turns command, data and init requests into
// timed pin phases (RS, D4..D7, E and hold time).
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Word
//  req_    | in        | valid / ready      | operation, value
//  rsp_    | out       | valid / ready      | reg_select, nibble, enable, hold_us, last
//  csr_    | in        | write enable only  | index, wdata (8 bits)
//
// A request is taken while the sequencer is idle, then one pin phase is issued
// per cycle while the result side is ready: 6 phases for a command or data
// byte, 37 for init. Phases leave through a single output register; a stalled
// result side holds the sequencer. Reset is synchronous and restores the setup
// registers.
// ----------------------------------------------------------------------------
module char_lcd_nibble_interface_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write,
   input  logic [1:0]                  csr_index,
   input  logic [7:0]                  csr_wdata,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_operation,
   input  logic [7:0]                  req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_reg_select,
   output logic [3:0]                  rsp_nibble,
   output logic                        rsp_enable,
   output logic [clni_pkg::HOLD_W-1:0] rsp_hold_us,
   output logic                        rsp_last
);
   import clni_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   // Sequencer
   clni_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd)
   );

   // Datapath and output register
   clni_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_operation  (req_operation),
      .req_value      (req_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_reg_select (rsp_reg_select),
      .rsp_nibble     (rsp_nibble),
      .rsp_enable     (rsp_enable),
      .rsp_hold_us    (rsp_hold_us),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== hdl/clni_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clni_ctrl
// Phase sequencer: walks power-up wait, nibbles and pin phases.
// ----------------------------------------------------------------------------
module clni_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_operation,
   input  clni_pkg::dp_status_type status,
   output clni_pkg::ctl_cmd_type   cmd
);
   import clni_pkg::*;

   ctl_state_type    state_ff, state_in;
   logic [NIB_W-1:0] nib_ff, nib_in;
   logic [1:0]       ph_ff, ph_in;
   logic             init_ff, init_in;
   logic             op_ok;
   logic             at_end;
   logic [NIB_W-1:0] last_nib;

   assign op_ok    = (req_operation == OP_COMMAND) || (req_operation == OP_DATA) ||
                     (req_operation == OP_INIT);
   assign last_nib = init_ff ? NIB_LAST_INIT : NIB_LAST_BYTE;
   assign at_end   = (nib_ff == last_nib) && (ph_ff == PH_SETTLE);

   // Next state and counters
   always_comb begin
      state_in = state_ff;
      nib_in   = nib_ff;
      ph_in    = ph_ff;
      init_in  = init_ff;
      unique case (state_ff)
         ST_IDLE: begin
            nib_in = '0;
            ph_in  = PH_SETUP;
            if (req_valid && op_ok) begin
               init_in  = (req_operation == OP_INIT);
               state_in = (req_operation == OP_INIT) ? ST_POWERUP : ST_NIBBLE;
            end
         end
         ST_POWERUP: begin
            if (status.slot_free) state_in = ST_NIBBLE;
         end
         ST_NIBBLE: begin
            if (status.slot_free) begin
               if (ph_ff == PH_SETTLE) begin
                  ph_in = PH_SETUP;
                  if (at_end) state_in = ST_IDLE;
                  else        nib_in   = nib_ff + 1'b1;
               end else begin
                  ph_in = ph_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.init    = init_ff;
      cmd.nib     = nib_ff;
      cmd.ph      = ph_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid && op_ok;
         end
         ST_POWERUP: begin
            cmd.emit    = status.slot_free;
            cmd.powerup = 1'b1;
         end
         ST_NIBBLE: begin
            cmd.emit = status.slot_free;
            cmd.last = at_end;
         end
         default: req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         nib_ff   <= '0;
         ph_ff    <= PH_SETUP;
         init_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         nib_ff   <= nib_in;
         ph_ff    <= ph_in;
         init_ff  <= init_in;
      end
   end

endmodule

// ===== hdl/clni_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clni_dpath
// Setup registers, register-select state, phase decode and output word.
// ----------------------------------------------------------------------------
module clni_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [1:0]                    csr_index,
   input  logic [7:0]                    csr_wdata,
   input  logic [1:0]                    req_operation,
   input  logic [7:0]                    req_value,
   input  clni_pkg::ctl_cmd_type         cmd,
   output clni_pkg::dp_status_type       status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_reg_select,
   output logic [3:0]                    rsp_nibble,
   output logic                          rsp_enable,
   output logic [clni_pkg::HOLD_W-1:0]   rsp_hold_us,
   output logic                          rsp_last
);
   import clni_pkg::*;

   logic [7:0]        fset_ff, disp_ff, entry_ff;
   logic              rs_level_ff, rs_cap_ff, data_ff;
   logic [7:0]        val_ff;
   logic              valid_ff;
   logic              rs_ff;
   logic [3:0]        nib_ff;
   logic              en_ff;
   logic [HOLD_W-1:0] hold_ff;
   logic              last_ff;

   logic [3:0]        nib_val;
   logic [HOLD_W-1:0] extra;
   logic [HOLD_W-1:0] hold_val;
   logic              rs_val;

   assign status.slot_free = !valid_ff || rsp_ready;

   // Setup registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fset_ff  <= FUNCTION_SET_RST;
         disp_ff  <= DISPLAY_CONTROL_RST;
         entry_ff <= ENTRY_MODE_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_FUNCTION_SET:    fset_ff  <= csr_wdata;
            CSR_DISPLAY_CONTROL: disp_ff  <= csr_wdata;
            CSR_ENTRY_MODE:      entry_ff <= csr_wdata;
            default:             ;
         endcase
      end
   end

   // Stored RS level; init leaves it low
   always_ff @(posedge clock) begin
      if (reset) rs_level_ff <= 1'b0;
      else if (cmd.start) rs_level_ff <= (req_operation == OP_DATA);
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rs_cap_ff <= rs_level_ff;
         data_ff   <= (req_operation == OP_DATA);
         val_ff    <= req_value;
      end
   end

   // Nibble level for the current slot
   always_comb begin
      if (cmd.init) begin
         case (cmd.nib) inside
            4'd0, 4'd1, 4'd2: nib_val = WAKE_NIB_A;
            4'd3:             nib_val = WAKE_NIB_B;
            4'd4:             nib_val = fset_ff[7:4];
            4'd5:             nib_val = fset_ff[3:0];
            4'd6:             nib_val = disp_ff[7:4];
            4'd7:             nib_val = disp_ff[3:0];
            4'd8:             nib_val = entry_ff[7:4];
            4'd9:             nib_val = entry_ff[3:0];
            4'd10:            nib_val = CLEAR_CMD[7:4];
            default:          nib_val = CLEAR_CMD[3:0];
         endcase
      end else begin
         nib_val = cmd.nib[0] ? val_ff[3:0] : val_ff[7:4];
      end
   end

   // Extra wait after the settle phase
   always_comb begin
      if (cmd.init) begin
         case (cmd.nib) inside
            4'd0, 4'd3:       extra = WAKE_LONG_US;
            4'd1, 4'd2:       extra = WAKE_SHRT_US;
            4'd5, 4'd7, 4'd9: extra = CMD_EXTRA_US;
            4'd11:            extra = CLR_EXTRA_US;
            default:          extra = '0;
         endcase
      end else if (cmd.nib[0]) begin
         extra = data_ff ? DAT_EXTRA_US : CMD_EXTRA_US;
      end else begin
         extra = '0;
      end
   end

   // Hold time per phase
   always_comb begin
      case (cmd.ph)
         PH_SETUP:  hold_val = SETUP_US;
         PH_STROBE: hold_val = STROBE_US;
         default:   hold_val = SETTLE_US + extra;
      endcase
   end

   // RS: wake-up nibbles keep the stored level, setup bytes are commands
   always_comb begin
      if (cmd.init) rs_val = (cmd.nib <= NIB_WAKE_END) ? rs_cap_ff : 1'b0;
      else          rs_val = data_ff;
   end

   // Output word register
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (cmd.emit) valid_ff <= 1'b1;
      else if (rsp_ready) valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (cmd.powerup) begin
            rs_ff   <= rs_cap_ff;
            nib_ff  <= '0;
            en_ff   <= 1'b0;
            hold_ff <= POWERUP_US;
            last_ff <= 1'b0;
         end else begin
            rs_ff   <= rs_val;
            nib_ff  <= nib_val;
            en_ff   <= (cmd.ph == PH_STROBE);
            hold_ff <= hold_val;
            last_ff <= cmd.last;
         end
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_reg_select = rs_ff;
   assign rsp_nibble     = nib_ff;
   assign rsp_enable     = en_ff;
   assign rsp_hold_us    = hold_ff;
   assign rsp_last       = last_ff;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 4-bit character LCD interface. Command, data,
// init and spare requests go in over the request channel; every pin phase
// that comes back is checked field by field against a phase predictor kept
// inside the bench. A short directed table comes first, then random requests
// under several setup register settings, with random sender bursts, receiver
// stalls, one long receiver hold-off and drains before each register update.
// ----------------------------------------------------------------------------
module tb;
   import clni_pkg::*;

   // spare operation code: no phases, no state change
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam int unsigned RESET_CYCLES    = 7;
   localparam int unsigned SETTLE_CYCLES   = 45;   // one init request plus margin
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned WATCHDOG_LIMIT  = 4000;
   localparam int unsigned RANDOM_PHASES   = 5;
   localparam int unsigned WORDS_PER_PHASE = 70;

   typedef struct packed {
      logic              rs;
      logic [3:0]        nib;
      logic              en;
      logic [HOLD_W-1:0] hold;
      logic              last;
   } lcd_phase_t;

   typedef struct {
      logic [1:0] op;
      logic [7:0] val;
      bit         typed;
      lcd_phase_t first;
   } dir_row_t;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_write;
   logic [1:0]        csr_index;
   logic [7:0]        csr_wdata;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_operation;
   logic [7:0]        req_value;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_reg_select;
   logic [3:0]        rsp_nibble;
   logic              rsp_enable;
   logic [HOLD_W-1:0] rsp_hold_us;
   logic              rsp_last;

   // typed first phase travelling with the current request word
   bit         row_typed;
   lcd_phase_t row_first;

   // predictor state: stored RS level and setup bytes
   logic       pred_rs;
   logic [7:0] pred_func_set;
   logic [7:0] pred_disp_ctl;
   logic [7:0] pred_entry_mode;

   lcd_phase_t pending_phases[$];
   dir_row_t   dir_rows[$];

   int unsigned bad_words;
   int unsigned phases_checked;
   int unsigned n_cmd, n_dat, n_init, n_spare;
   int unsigned idle_cycles;
   int unsigned burst_left;
   bit          stall_request;
   bit          stall_done;

   char_lcd_nibble_interface_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_reg_select (rsp_reg_select),
      .rsp_nibble     (rsp_nibble),
      .rsp_enable     (rsp_enable),
      .rsp_hold_us    (rsp_hold_us),
      .rsp_last       (rsp_last)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Phase predictor
   // ------------------------------------------------------------------------
   function automatic void push_phase(input logic rs, input logic [3:0] nib,
                                      input logic en, input logic [HOLD_W-1:0] hold);
      lcd_phase_t p;
      p = '{rs, nib, en, hold, 1'b0};
      pending_phases.push_back(p);
   endfunction

   // setup, strobe, settle (settle carries any following wait)
   function automatic void push_nibble(input logic rs, input logic [3:0] nib,
                                       input logic [HOLD_W-1:0] extra);
      push_phase(rs, nib, 1'b0, SETUP_US);
      push_phase(rs, nib, 1'b1, STROBE_US);
      push_phase(rs, nib, 1'b0, SETTLE_US + extra);
   endfunction

   // high nibble first
   function automatic void push_byte(input logic rs, input logic [7:0] b,
                                     input logic [HOLD_W-1:0] extra);
      push_nibble(rs, b[7:4], '0);
      push_nibble(rs, b[3:0], extra);
   endfunction

   // expand one request into its pin phases and flag the final one
   function automatic void expand_request(input logic [1:0] op, input logic [7:0] val);
      logic       rs;
      lcd_phase_t tail;
      case (op)
         OP_COMMAND: begin
            pred_rs = 1'b0;
            push_byte(1'b0, val, CMD_EXTRA_US);
         end
         OP_DATA: begin
            pred_rs = 1'b1;
            push_byte(1'b1, val, DAT_EXTRA_US);
         end
         OP_INIT: begin
            // wake-up part keeps the stored RS level
            rs = pred_rs;
            push_phase(rs, 4'h0, 1'b0, POWERUP_US);
            push_nibble(rs, WAKE_NIB_A, WAKE_LONG_US);
            push_nibble(rs, WAKE_NIB_A, WAKE_SHRT_US);
            push_nibble(rs, WAKE_NIB_A, WAKE_SHRT_US);
            push_nibble(rs, WAKE_NIB_B, WAKE_LONG_US);
            pred_rs = 1'b0;
            push_byte(1'b0, pred_func_set, CMD_EXTRA_US);
            push_byte(1'b0, pred_disp_ctl, CMD_EXTRA_US);
            push_byte(1'b0, pred_entry_mode, CMD_EXTRA_US);
            push_byte(1'b0, CLEAR_CMD, CLR_EXTRA_US);
         end
         default: return;
      endcase
      tail = pending_phases.pop_back();
      tail.last = 1'b1;
      pending_phases.push_back(tail);
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: predictor update on each accepted word, result check, watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      int         base;
      lcd_phase_t got;
      lcd_phase_t want;
      if (reset) begin
         pred_rs         = 1'b0;
         pred_func_set   = FUNCTION_SET_RST;
         pred_disp_ctl   = DISPLAY_CONTROL_RST;
         pred_entry_mode = ENTRY_MODE_RST;
         idle_cycles     = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_FUNCTION_SET:    pred_func_set   = csr_wdata;
               CSR_DISPLAY_CONTROL: pred_disp_ctl   = csr_wdata;
               CSR_ENTRY_MODE:      pred_entry_mode = csr_wdata;
               default: ;
            endcase
         end

         // request word taken: queue its phases, typed first phase wins
         if (req_valid && req_ready) begin
            base = pending_phases.size();
            expand_request(req_operation, req_value);
            if (row_typed && pending_phases.size() > base)
               pending_phases[base] = row_first;
            case (req_operation)
               OP_COMMAND: n_cmd++;
               OP_DATA:    n_dat++;
               OP_INIT:    n_init++;
               default:    n_spare++;
            endcase
         end

         // result word: compare with the oldest expected phase
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_reg_select, rsp_nibble, rsp_enable, rsp_hold_us, rsp_last};
            if (pending_phases.size() == 0) begin
               bad_words++;
               if (bad_words <= 10)
                  $display("%0t: unexpected phase rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                           $realtime, got.rs, got.nib, got.en, got.hold, got.last);
            end else begin
               want = pending_phases.pop_front();
               phases_checked++;
               if (got.rs !== want.rs || got.nib !== want.nib || got.en !== want.en ||
                   got.hold !== want.hold || got.last !== want.last) begin
                  bad_words++;
                  if (bad_words <= 10)
                     $display("%0t: phase %0d mismatch exp rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                              $realtime, phases_checked, want.rs, want.nib, want.en,
                              want.hold, want.last,
                              "  got rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                              got.rs, got.nib, got.en, got.hold, got.last);
               end
            end
         end

         // watchdog on cycles with no word moving on either channel
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles, %0d phases outstanding",
                     idle_cycles, pending_phases.size());
            $display("char_lcd_nibble_interface_top test failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: stall pattern of its own, plus one long hold-off on request
   // ------------------------------------------------------------------------
   initial begin : receiver
      int unsigned mode;
      int unsigned seg;
      int unsigned period;
      rsp_ready <= 1'b0;
      forever begin
         mode   = $urandom_range(0, 3);
         seg    = $urandom_range(10, 150);
         period = $urandom_range(2, 5);
         for (int unsigned i = 0; i < seg; i++) begin
            @(posedge clock);
            if (stall_request && !stall_done) begin
               rsp_ready <= 1'b0;
               repeat (HOLD_OFF_CYCLES) @(posedge clock);
               stall_done = 1'b1;
            end else begin
               case (mode)
                  0:       rsp_ready <= 1'b1;
                  1:       rsp_ready <= 1'($urandom_range(0, 1));
                  2:       rsp_ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_ready <= ((i % period) != 0);
               endcase
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sender helpers
   // ------------------------------------------------------------------------
   // offer one request word and hold it until taken
   task automatic send_word(input logic [1:0] op, input logic [7:0] val,
                            input bit typed, input lcd_phase_t first);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value     <= val;
      row_typed     <= typed;
      row_first     <= first;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // bursts of back-to-back words with random gaps between them
   task automatic pace();
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
                                                   : $urandom_range(1, 8);
      end else begin
         burst_left--;
      end
   endtask

   // wait for every expected phase, then wait out one init request plus margin
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_phases.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all three setup registers, one per cycle
   task automatic program_setup(input logic [7:0] func_set, input logic [7:0] disp_ctl,
                                input logic [7:0] entry_mode);
      logic [1:0] idx[3];
      logic [7:0] dat[3];
      idx = '{CSR_FUNCTION_SET, CSR_DISPLAY_CONTROL, CSR_ENTRY_MODE};
      dat = '{func_set, disp_ctl, entry_mode};
      for (int i = 0; i < 3; i++) begin
         csr_write <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= dat[i];
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   function automatic void add_row(input logic [1:0] op, input logic [7:0] val,
                                   input bit typed, input logic rs, input logic [3:0] nib,
                                   input logic en, input logic [HOLD_W-1:0] hold);
      dir_row_t r;
      r.op    = op;
      r.val   = val;
      r.typed = typed;
      r.first = '{rs, nib, en, hold, 1'b0};
      dir_rows.push_back(r);
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int unsigned pick;
      logic [1:0]  op;
      reset         <= 1'b1;
      csr_write     <= 1'b0;
      csr_index     <= CSR_FUNCTION_SET;
      csr_wdata     <= '0;
      req_valid     <= 1'b0;
      req_operation <= OP_COMMAND;
      req_value     <= '0;
      row_typed     <= 1'b0;
      row_first     <= '0;
      burst_left    = 0;
      stall_request = 1'b0;
      stall_done    = 1'b0;

      // directed table: first phase typed in where obvious
      //        op          value  typed rs  nib  en    hold
      add_row(OP_INIT,    8'h00, 1, 1'b0, 4'h0, 1'b0, POWERUP_US); // straight after reset
      add_row(OP_COMMAND, 8'h00, 1, 1'b0, 4'h0, 1'b0, SETUP_US);
      add_row(OP_COMMAND, 8'hFF, 1, 1'b0, 4'hF, 1'b0, SETUP_US);
      add_row(OP_DATA,    8'h00, 1, 1'b1, 4'h0, 1'b0, SETUP_US);
      add_row(OP_DATA,    8'hFF, 1, 1'b1, 4'hF, 1'b0, SETUP_US);
      add_row(OP_INIT,    8'h00, 1, 1'b1, 4'h0, 1'b0, POWERUP_US); // keeps data RS level
      add_row(OP_SPARE,   8'h5A, 0, 1'b0, 4'h0, 1'b0, '0);
      add_row(OP_INIT,    8'h00, 1, 1'b0, 4'h0, 1'b0, POWERUP_US); // init leaves RS low
      add_row(OP_DATA,    8'hA5, 0, 1'b0, 4'h0, 1'b0, '0);
      add_row(OP_SPARE,   8'hFF, 0, 1'b0, 4'h0, 1'b0, '0);
      add_row(OP_INIT,    8'hFF, 1, 1'b1, 4'h0, 1'b0, POWERUP_US); // value ignored
      add_row(OP_COMMAND, CLEAR_CMD, 0, 1'b0, 4'h0, 1'b0, '0);
      add_row(OP_COMMAND, 8'h80, 0, 1'b0, 4'h0, 1'b0, '0);
      add_row(OP_DATA,    8'h55, 0, 1'b0, 4'h0, 1'b0, '0);
      add_row(OP_DATA,    8'hAA, 0, 1'b0, 4'h0, 1'b0, '0);
      add_row(OP_COMMAND, 8'h0F, 0, 1'b0, 4'h0, 1'b0, '0);
      add_row(OP_DATA,    8'h30, 0, 1'b0, 4'h0, 1'b0, '0);
      add_row(OP_SPARE,   8'h00, 0, 1'b0, 4'h0, 1'b0, '0);
      add_row(OP_DATA,    8'h7E, 0, 1'b0, 4'h0, 1'b0, '0);
      add_row(OP_INIT,    8'h00, 0, 1'b0, 4'h0, 1'b0, '0);
      add_row(OP_COMMAND, 8'hC3, 0, 1'b0, 4'h0, 1'b0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, setup registers at reset values
      foreach (dir_rows[i]) begin
         send_word(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].first);
         pace();
      end
      drain();

      // random part over several setup settings
      for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0:       program_setup(8'h00, 8'h00, 8'h00);
            1:       program_setup(8'hFF, 8'hFF, 8'hFF);
            3:       program_setup(FUNCTION_SET_RST, DISPLAY_CONTROL_RST, ENTRY_MODE_RST);
            default: program_setup(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)));
         endcase
         // long receiver hold-off while requests keep coming
         if (ph == 2)
            stall_request = 1'b1;
         for (int unsigned n = 0; n < WORDS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      op = OP_COMMAND;
            else if (pick < 85) op = OP_DATA;
            else if (pick < 93) op = OP_INIT;
            else                op = OP_SPARE;
            send_word(op, 8'($urandom_range(0, 255)), 1'b0, '0);
            pace();
         end
         drain();
      end

      if (pending_phases.size() != 0)
         bad_words++;
      $display("covered %0d commands, %0d data, %0d inits, %0d spare requests",
               n_cmd, n_dat, n_init, n_spare);
      $display("%0d pin phases checked over %0d setup settings, %0d failures",
               phases_checked, RANDOM_PHASES + 1, bad_words);
      if (bad_words == 0)
         $display("char_lcd_nibble_interface_top test passed");
      else
         $display("char_lcd_nibble_interface_top test failed");
      $finish;
   end

endmodule
